>>> rtl/rtd_pkg.sv
// Shared constants, types and the digit-to-ASCII function of the radix to ASCII digits unit.
package rtd_pkg;

  // Sizes of the value and of the digit store.
  localparam int VALUE_BITS  = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int BASE_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  // Character and radix constants.
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'd65;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Status that the serial divider reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic quot_zero;
  } div_status_t;

  // ASCII code of one digit value: '0'..'9', then 'A'..'Z'.
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < DIGIT_TEN) begin
      code = CHAR_ZERO + CHAR_W'(d);
    end else begin
      code = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
    return code;
  endfunction

endpackage

>>> rtl/rtd_div.sv
// Bit-serial restoring divider that yields one digit (remainder) and the quotient.
module rtd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rtd_pkg::VALUE_BITS-1:0]   dividend,
  input  logic [rtd_pkg::BASE_W-1:0]       divisor,
  output rtd_pkg::div_status_t             status,
  output logic [rtd_pkg::DIGIT_W-1:0]      digit,
  output logic [rtd_pkg::VALUE_BITS-1:0]   quotient
);

  logic [rtd_pkg::VALUE_BITS-1:0] quot;
  logic [rtd_pkg::DIGIT_W-1:0]    rem;
  logic [rtd_pkg::BIT_CNT_W-1:0]  bit_cnt;
  logic                           busy;
  logic                           done;

  logic [rtd_pkg::DIGIT_W:0]      trial;
  logic [rtd_pkg::DIGIT_W:0]      diff;
  logic                           ge;
  logic [rtd_pkg::DIGIT_W-1:0]    rem_next;

  // One quotient bit per cycle: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, quot[rtd_pkg::VALUE_BITS-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? diff[rtd_pkg::DIGIT_W-1:0] : trial[rtd_pkg::DIGIT_W-1:0];
  end

  // Control: bit counter, busy flag and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == rtd_pkg::BIT_CNT_W'(rtd_pkg::VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[rtd_pkg::VALUE_BITS-2:0], ge};
      rem  <= rem_next;
    end
  end

  assign status.busy      = busy;
  assign status.done      = done;
  assign status.quot_zero = (quot == '0);
  assign digit            = rem;
  assign quotient         = quot;

endmodule

>>> rtl/radix_to_ascii_digits_unit.sv
// Top level of the radix to ASCII digits unit: sequencer, digit stack and output register.
//
// Each accepted value is divided repeatedly by the configured base (clamped to 2..36) in a
// bit-serial divider that works through the value bit by bit: every digit takes a shift
// for each value bit and then a done pulse that also starts the division for the next digit.
// Digits are pushed onto a shift-register stack and then popped most significant first, one
// character per cycle while the output is taken. A 32-bit value in base 10 needs at most
// ten digits; base 2 needs up to 32 digits. Zero gives the single character '0'. Only one
// value is in work at a time; the input is ready again once the last character has been
// loaded into the output register. The base must be written through base_we/base_wdata
// only while the unit is idle; the block itself does not enforce this.
module radix_to_ascii_digits_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write of the base register.
  input  logic                               base_we,
  input  logic [rtd_pkg::BASE_W-1:0]         base_wdata,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rtd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] value
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rtd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [6:0] char_code, [7] zero pad
  output logic                               m_axis_tlast   // last
);

  rtd_pkg::state_t                state;
  rtd_pkg::state_t                state_next;
  logic [rtd_pkg::BASE_W-1:0]     base;
  logic [rtd_pkg::BASE_W-1:0]     base_use;
  logic [rtd_pkg::BASE_W-1:0]     base_clamped;
  logic [rtd_pkg::DIGIT_W-1:0]    stack [rtd_pkg::MAX_DIGITS];
  logic [rtd_pkg::CNT_W-1:0]      count;
  logic [rtd_pkg::CHAR_W-1:0]     out_char;
  logic                           out_last;
  logic                           out_valid;

  logic                           in_xfer;
  logic                           div_start;
  logic                           push;
  logic                           pop;
  logic                           out_free;
  logic                           more_digits;
  logic [rtd_pkg::VALUE_BITS-1:0] dividend;
  rtd_pkg::div_status_t           div_status;
  logic [rtd_pkg::DIGIT_W-1:0]    div_digit;
  logic [rtd_pkg::VALUE_BITS-1:0] div_quot;

  // Base register and its clamped form.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= rtd_pkg::BASE_RESET;
    end else if (base_we) begin
      base <= base_wdata;
    end
  end

  always_comb begin
    priority if (base < rtd_pkg::BASE_MIN) begin
      base_clamped = rtd_pkg::BASE_MIN;
    end else if (base > rtd_pkg::BASE_MAX) begin
      base_clamped = rtd_pkg::BASE_MAX;
    end else begin
      base_clamped = base;
    end
  end

  // The base is held for the whole item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      base_use <= base_clamped;
    end
  end

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid || m_axis_tready;
  assign more_digits = !div_status.quot_zero &&
                       (count != rtd_pkg::CNT_W'(rtd_pkg::MAX_DIGITS - 1));
  assign dividend    = (state == rtd_pkg::ST_IDLE) ?
                       s_axis_tdata[rtd_pkg::VALUE_BITS-1:0] : div_quot;

  rtd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (base_use),
    .status   (div_status),
    .digit    (div_digit),
    .quotient (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      rtd_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = rtd_pkg::ST_DIVIDE;
        end
      end
      rtd_pkg::ST_DIVIDE: begin
        if (div_status.done && !more_digits) begin
          state_next = rtd_pkg::ST_EMIT;
        end
      end
      rtd_pkg::ST_EMIT: begin
        if (out_free && count == rtd_pkg::CNT_W'(1)) begin
          state_next = rtd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtd_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    unique case (state)
      rtd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid;
      end
      rtd_pkg::ST_DIVIDE: begin
        push      = div_status.done;
        div_start = div_status.done && more_digits;
      end
      rtd_pkg::ST_EMIT: begin
        pop = out_free && (count != '0);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count of the digit stack.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count + 1'b1;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

  // Digit stack: a push shifts every entry up, a pop shifts every entry down.
  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= div_digit;
      for (int i = 1; i < rtd_pkg::MAX_DIGITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < rtd_pkg::MAX_DIGITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  // Output register: loaded from the top of the stack, cleared once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_char <= rtd_pkg::ascii_of(stack[0]);
      out_last <= (count == rtd_pkg::CNT_W'(1));
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(rtd_pkg::OUT_TDATA_W - rtd_pkg::CHAR_W){1'b0}}, out_char};
  assign m_axis_tlast  = out_last;

endmodule

>>> rtl/rtd_chk.sv
// Port-level checker for the radix to ASCII digits unit, bound to the top level.
module rtd_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rtd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  // A stalled output transfer keeps its character and its last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Every character is a digit or an upper-case letter, with the pad bit clear.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[7] == 1'b0) &&
      ((m_axis_tdata[6:0] >= 7'd48 && m_axis_tdata[6:0] <= 7'd57) ||
       (m_axis_tdata[6:0] >= 7'd65 && m_axis_tdata[6:0] <= 7'd90)))
    else $error("illegal character code");

  // Only one value is in work: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after a transfer");

  // Reset leaves no character pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind radix_to_ascii_digits_unit rtd_chk u_rtd_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> test/radix_to_ascii_digits_unit_tb.sv
// Self-checking testbench of the radix to ASCII digits unit with random stalls on both streams.
`timescale 1ns / 1ps

module radix_to_ascii_digits_unit_tb;

  // Worst case: about 230 values of 32 digits, each digit with its serial divide plus
  // a long output stall; the limit leaves several times the total of that.
  localparam int unsigned LIMIT_CYCLES   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned RX_HOLD_CYCLES = 600;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 20;

  // One expected character of the output stream.
  typedef struct packed {
    logic [rtd_pkg::CHAR_W-1:0] char_code;
    logic                       is_last;
  } char_item_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            base_we       = 1'b0;
  logic [rtd_pkg::BASE_W-1:0]      base_wdata    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rtd_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rtd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  char_item_t                 expected_chars[$];
  logic [rtd_pkg::BASE_W-1:0] base_cfg      = rtd_pkg::BASE_RESET;
  int unsigned                error_count   = 0;
  int unsigned                cycle_count   = 0;
  bit                         tx_idle_en    = 1'b1;
  bit                         rx_idle_en    = 1'b1;
  int unsigned                hold_token    = 0;
  int unsigned                hold_seen     = 0;
  int unsigned                rx_hold_left  = 0;
  int unsigned                rx_stall_left = 0;

  radix_to_ascii_digits_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .base_we      (base_we),
    .base_wdata   (base_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] value
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [6:0] char_code, [7] zero pad
    .m_axis_tlast (m_axis_tlast)    // last
  );

  // Clock generation.
  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Length of one idle stretch: mostly short, now and then long.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Expected characters of one value under the current base, most significant first.
  function automatic void predict_digits(input logic [rtd_pkg::IN_TDATA_W-1:0] value);
    logic [rtd_pkg::DIGIT_W-1:0] digits[rtd_pkg::MAX_DIGITS];
    longint unsigned             rest;
    int unsigned                 radix;
    int                          n;
    char_item_t                  item;
    if (base_cfg < rtd_pkg::BASE_MIN) begin
      radix = 32'(rtd_pkg::BASE_MIN);
    end else if (base_cfg > rtd_pkg::BASE_MAX) begin
      radix = 32'(rtd_pkg::BASE_MAX);
    end else begin
      radix = 32'(base_cfg);
    end
    rest = 64'(value);
    n = 0;
    // A zero value still yields one digit.
    do begin
      digits[n] = rtd_pkg::DIGIT_W'(rest % radix);
      rest = rest / radix;
      n++;
    end while (rest != 0 && n < rtd_pkg::MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < rtd_pkg::DIGIT_TEN) begin
        item.char_code = rtd_pkg::CHAR_ZERO + rtd_pkg::CHAR_W'(digits[k]);
      end else begin
        item.char_code = rtd_pkg::CHAR_A + rtd_pkg::CHAR_W'(digits[k] - rtd_pkg::DIGIT_TEN);
      end
      item.is_last = (k == 0);
      expected_chars.push_back(item);
    end
  endfunction

  // Random value with a spread of magnitudes so that digit counts vary widely.
  function automatic logic [rtd_pkg::IN_TDATA_W-1:0] pick_value();
    unique case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(1, 31);
      2: return $urandom_range(0, 40);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
      rx_stall_left = idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected character.
  always @(posedge clk) begin
    char_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code %0d, last %0b",
               m_axis_tdata[rtd_pkg::CHAR_W-1:0], m_axis_tlast);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata[rtd_pkg::CHAR_W-1:0] !== want.char_code) begin
          $error("char_code mismatch: expected %0d, actual %0d", want.char_code,
                 m_axis_tdata[rtd_pkg::CHAR_W-1:0]);
          error_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("last mismatch: expected %0b, actual %0b", want.is_last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Offer one value, optionally after a gap, and record its characters once accepted.
  task automatic send_value(input logic [rtd_pkg::IN_TDATA_W-1:0] value);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    predict_digits(value);
  endtask

  // Stop offering and wait until every expected character has arrived.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the base register; only called while the unit is idle.
  task automatic set_base(input logic [rtd_pkg::BASE_W-1:0] radix);
    base_we    <= 1'b1;
    base_wdata <= radix;
    @(posedge clk);
    base_we  <= 1'b0;
    base_cfg = radix;
  endtask

  // Reset base of ten, including zero and the all-ones value.
  task automatic test_default_base();
    send_value(0);
    send_value(9);
    send_value(10);
    send_value('1);
    wait_results_done();
  endtask

  // Smallest and largest bases, letter digits, and bases that must be clamped.
  task automatic test_base_extremes();
    set_base(rtd_pkg::BASE_MIN);
    send_value('1);
    send_value(1);
    wait_results_done();
    set_base(rtd_pkg::BASE_MAX);
    send_value(35);
    send_value(36);
    send_value('1);
    wait_results_done();
    set_base(6'd16);
    send_value(32'hABCDEF01);
    wait_results_done();
    // Bases below two behave as two, above thirty-six as thirty-six.
    set_base(6'd0);
    send_value(5);
    wait_results_done();
    set_base(6'd1);
    send_value(32'h8000_0000);
    wait_results_done();
    set_base(6'd37);
    send_value(1295);
    wait_results_done();
    set_base(6'd63);
    send_value(0);
    wait_results_done();
  endtask

  // Long receiver hold-off while values keep coming, so the input stalls.
  task automatic test_input_stall();
    set_base(rtd_pkg::BASE_MAX);
    tx_idle_en = 1'b0;
    hold_token <= hold_token + 1;
    repeat (5) send_value($urandom_range(0, 1295));
    wait_results_done();
    tx_idle_en = 1'b1;
  endtask

  // Sender pauses until each value is fully drained before the next.
  task automatic test_sender_pause();
    set_base(6'd16);
    repeat (5) begin
      send_value(pick_value());
      wait_results_done();
    end
  endtask

  // Random values in phases, each with its own base and idling mix.
  task automatic test_random_values();
    logic [rtd_pkg::BASE_W-1:0] radix;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_results_done();
      if ($urandom_range(0, 9) < 2) begin
        radix = rtd_pkg::BASE_W'($urandom_range(0, 63));
      end else begin
        radix = rtd_pkg::BASE_W'($urandom_range(rtd_pkg::BASE_MIN, rtd_pkg::BASE_MAX));
      end
      set_base(radix);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_value(pick_value());
    end
    rx_idle_en <= 1'b1;
    tx_idle_en = 1'b1;
  endtask

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_base();
    test_base_extremes();
    test_input_stall();
    test_sender_pause();
    test_random_values();
    wait_results_done();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
